// ----- src/aesk_pkg.sv -----
`default_nettype none

package aesk_pkg;

  localparam int unsigned KeyWidth   = 128;
  localparam int unsigned RoundWidth = 4;
  localparam int unsigned Rounds     = 10;  // last round key index (0..10)

  typedef logic [KeyWidth-1:0]   key_t;
  typedef logic [RoundWidth-1:0] round_t;

  // Input selector carried in tuser
  typedef enum logic {
    ActLoad    = 1'b0,
    ActAdvance = 1'b1
  } action_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant for the step that leaves round index r
  function automatic logic [7:0] rcon(input round_t r);
    logic [7:0] c;
    case (r)
      4'd0:    c = 8'h01;
      4'd1:    c = 8'h02;
      4'd2:    c = 8'h04;
      4'd3:    c = 8'h08;
      4'd4:    c = 8'h10;
      4'd5:    c = 8'h20;
      4'd6:    c = 8'h40;
      4'd7:    c = 8'h80;
      4'd8:    c = 8'h1b;
      4'd9:    c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/aes128_round_key_generator_core.sv -----
`default_nettype none
// The result of an input transfer is registered and shows on the master side in the next cycle.
// Throughput: 1 item per cycle unless output stalls; the key/round state updates at
//   the input transfer and the next round key is derived from it in the same cycle.
// Reset (rst_ni low, async): key state zero, round 0, no result pending.
// An output register splits the sides; input stalls only while it is full.

module aes128_round_key_generator_core import aesk_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input stream
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [127:0] s_axis_tdata_i,   // [63:0] key_hi, [127:64] key_lo
  input  wire logic [0:0]   s_axis_tuser_i,   // [0] action (0 load, 1 advance)
  // Result stream
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [135:0]      m_axis_tdata_o,   // [63:0] round_hi, [127:64] round_lo,
                                              // [131:128] round_number, [135:132] zero
  output logic [0:0]        m_axis_tuser_o    // [0] exhausted
);

  // Current round key: [127:64] high half (words 0,1), [63:0] low half (words 2,3)
  key_t   key_q, key_d;
  round_t round_q, round_d;
  key_t   next_key;

  logic         out_valid_q;
  logic [135:0] out_data_q, out_data_d;
  logic         out_exh_q, out_exh_d;

  logic in_xfer;
  logic out_xfer;

  assign out_xfer        = out_valid_q & m_axis_tready_i;
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;

  aesk_round u_round (
    .key_i   (key_q),
    .round_i (round_q),
    .key_o   (next_key)
  );

  always_comb begin
    key_d     = key_q;
    round_d   = round_q;
    out_exh_d = 1'b0;
    if (action_e'(s_axis_tuser_i[0]) == ActLoad) begin
      // tdata low half is key_hi, upper half key_lo
      key_d   = {s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]};
      round_d = '0;
    end else if (round_q >= RoundWidth'(Rounds)) begin
      // schedule used up: hold key, flag it
      out_exh_d = 1'b1;
    end else begin
      key_d   = next_key;
      round_d = round_q + RoundWidth'(1);
    end
    out_data_d = {4'h0, round_d, key_d[63:0], key_d[127:64]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        key_q       <= key_d;
        round_q     <= round_d;
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
      out_exh_q  <= out_exh_d;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_exh_q;

endmodule

`default_nettype wire

// ----- src/aesk_round.sv -----
`default_nettype none

// One step of the AES-128 key schedule.
module aesk_round import aesk_pkg::*; (
  input  key_t   key_i,
  input  round_t round_i,
  output key_t   key_o
);

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] rot, sub, t;
  logic [31:0] n0, n1, n2, n3;

  assign w0 = key_i[127:96];
  assign w1 = key_i[95:64];
  assign w2 = key_i[63:32];
  assign w3 = key_i[31:0];

  assign rot = {w3[23:0], w3[31:24]};
  assign sub = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
  assign t   = sub ^ {rcon(round_i), 24'h000000};

  assign n0 = w0 ^ t;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;

  assign key_o = {n0, n1, n2, n3};

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import aesk_pkg::*;

  // One round key as it leaves the block
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    round_t      num;
    logic        exhausted;
  } round_key_t;

  logic         clk      = 1'b0;
  logic         rst_n    = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata  = '0;
  logic [0:0]   s_tuser  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic [0:0]   m_tuser;

  // Schedule state as the testbench tracks it: {w0, w1, w2, w3}
  logic [127:0] sched_key   = '0;
  round_t       sched_round = '0;
  round_key_t   pending_keys[$];

  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 45;
  int unsigned err_count     = 0;

  aes128_round_key_generator_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #10 clk = ~clk;

  // GF(2^8) arithmetic, AES polynomial
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_xtime(a);
    end
    return p;
  endfunction

  // S-box derived from its definition: inverse (x^254) then affine map
  function automatic logic [7:0] sbox_byte(input logic [7:0] x);
    logic [7:0] inv;
    logic [7:0] sq;
    inv = 8'h01;
    sq  = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) inv = gf_mul(inv, sq);
      sq = gf_mul(sq, sq);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [7:0] rcon_byte(input round_t r);
    logic [7:0] c;
    c = 8'h01;
    repeat (r) c = gf_xtime(c);
    return c;
  endfunction

  function automatic logic [127:0] next_round_key(input logic [127:0] k, input round_t r);
    logic [31:0] w0, w1, w2, w3, t;
    {w0, w1, w2, w3} = k;
    // RotWord then SubWord on the last word, round constant into the top byte
    t = {sbox_byte(w3[23:16]), sbox_byte(w3[15:8]), sbox_byte(w3[7:0]),
         sbox_byte(w3[31:24])} ^ {rcon_byte(r), 24'h0};
    w0 ^= t;
    w1 ^= w0;
    w2 ^= w1;
    w3 ^= w2;
    return {w0, w1, w2, w3};
  endfunction

  task automatic predict_round_key(input action_e act, input logic [63:0] key_hi,
                                   input logic [63:0] key_lo);
    round_key_t exp_key;
    exp_key.exhausted = 1'b0;
    if (act == ActLoad) begin
      sched_key   = {key_hi, key_lo};
      sched_round = '0;
    end else if (sched_round >= Rounds) begin
      exp_key.exhausted = 1'b1;
    end else begin
      sched_key   = next_round_key(sched_key, sched_round);
      sched_round = sched_round + 1'b1;
    end
    exp_key.hi  = sched_key[127:64];
    exp_key.lo  = sched_key[63:0];
    exp_key.num = sched_round;
    pending_keys.push_back(exp_key);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    // keep the log short when everything goes wrong
    if (err_count < 40) $display("%0t ns: %s got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_round_key();
    round_key_t exp_key;
    if (pending_keys.size() == 0) begin
      report_mismatch("result with none pending, round_hi", m_tdata[63:0], '0);
      return;
    end
    exp_key = pending_keys.pop_front();
    if (m_tdata[63:0] !== exp_key.hi) report_mismatch("round_hi", m_tdata[63:0], exp_key.hi);
    if (m_tdata[127:64] !== exp_key.lo)
      report_mismatch("round_lo", m_tdata[127:64], exp_key.lo);
    if (m_tdata[131:128] !== exp_key.num)
      report_mismatch("round_number", m_tdata[131:128], exp_key.num);
    if (m_tdata[135:132] !== 4'h0) report_mismatch("tdata pad", m_tdata[135:132], '0);
    if (m_tuser[0] !== exp_key.exhausted)
      report_mismatch("exhausted", m_tuser[0], exp_key.exhausted);
  endtask

  // Result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_tvalid && m_tready) check_round_key();
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input action_e act, input logic [63:0] key_hi,
                           input logic [63:0] key_lo);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(4, 1);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {key_lo, key_hi};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    predict_round_key(act, key_hi, key_lo);
  endtask

  function automatic logic [63:0] rand_key_half();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return {8{8'($urandom)}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Advances straight out of reset expand the all-zero key
  task automatic test_unloaded_start();
    repeat (2) send_item(ActAdvance, rand_key_half(), rand_key_half());
  endtask

  // Standard AES-128 example key through all rounds and past the end twice
  task automatic test_reference_schedule();
    send_item(ActLoad, 64'h2b7e1516_28aed2a6, 64'habf71588_09cf4f3c);
    repeat (12) send_item(ActAdvance, '1, '0);
  endtask

  task automatic test_key_extremes();
    send_item(ActLoad, '0, '0);
    send_item(ActAdvance, '0, '0);
    send_item(ActLoad, '1, '1);
    send_item(ActAdvance, '1, '1);
    send_item(ActLoad, {4{16'haaaa}}, {4{16'h5555}});
    send_item(ActAdvance, '0, '1);
  endtask

  // Mostly load-then-advance runs, some reaching exhaustion; rest is noise
  task automatic test_random_schedules(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_adv;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        n_adv = ($urandom_range(99) < 40) ? $urandom_range(13, 10) : $urandom_range(9, 0);
        send_item(ActLoad, rand_key_half(), rand_key_half());
        repeat (n_adv) send_item(ActAdvance, rand_key_half(), rand_key_half());
        sent += n_adv + 1;
      end else begin
        repeat (3) send_item(action_e'($urandom_range(1)), rand_key_half(), rand_key_half());
        sent += 3;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unloaded_start();
    test_reference_schedule();
    test_key_extremes();
    test_random_schedules(550);
    send_idle_pct = 45;
    recv_idle_pct = 21;
    test_random_schedules(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_schedules(550);
    s_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
